// ===== src/flg_pkg.sv =====
// Shared constants, configuration and controller/datapath interface types.
`default_nettype none

package flg_pkg;

    // Phase length ranges in milliseconds.
    localparam int STABLE_MIN_MS  = 2000;
    localparam int STABLE_MAX_MS  = 8000;
    localparam int FLICKER_MIN_MS = 500;
    localparam int FLICKER_MAX_MS = 3000;
    localparam int MAX_PWM        = 255;
    localparam int SURGE_RANGE    = 100;

    // Spans of the duration draws; an empty range gives a span of zero.
    localparam logic [15:0] STABLE_MIN  = 16'(STABLE_MIN_MS);
    localparam logic [15:0] FLICKER_MIN = 16'(FLICKER_MIN_MS);
    localparam logic [15:0] STABLE_SPAN =
        (STABLE_MAX_MS > STABLE_MIN_MS) ? 16'(STABLE_MAX_MS - STABLE_MIN_MS) : 16'd0;
    localparam logic [15:0] FLICKER_SPAN =
        (FLICKER_MAX_MS > FLICKER_MIN_MS) ? 16'(FLICKER_MAX_MS - FLICKER_MIN_MS) : 16'd0;
    localparam logic [15:0] SURGE_SPAN = 16'(SURGE_RANGE);
    localparam logic [7:0]  PWM_MAX    = 8'(MAX_PWM);

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_STABLE_LEVEL   = 3'd0;
    localparam logic [2:0] REG_STABLE_VAR     = 3'd1;
    localparam logic [2:0] REG_FLICKER_LOW    = 3'd2;
    localparam logic [2:0] REG_FLICKER_HIGH   = 3'd3;
    localparam logic [2:0] REG_SURGE_CHANCE   = 3'd4;
    localparam logic [2:0] REG_SURGE_BOOST    = 3'd5;
    localparam logic [2:0] REG_REDRAW_IVAL    = 3'd6;
    localparam logic [2:0] REG_SMOOTH_ALPHA   = 3'd7;

    typedef struct packed {
        logic [7:0]  stable_level;
        logic [6:0]  stable_variation;
        logic [7:0]  flicker_low;
        logic [7:0]  flicker_high;
        logic [7:0]  surge_chance;
        logic [7:0]  surge_boost;
        logic [15:0] redraw_interval_ms;
        logic [8:0]  smoothing_alpha;
    } cfg_t;

    // One step strobe per datapath operation; at most one is high.
    typedef struct packed {
        logic load;
        logic phase;
        logic surge;
        logic boost;
        logic len;
        logic target;
        logic smooth;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic lamp_on;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/flg_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module flg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [flg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [flg_pkg::DATA_W-1:0] pwdata,
    output logic      [flg_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output flg_pkg::cfg_t                   cfg
);
    import flg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_STABLE_LEVEL: cfg_next.stable_level       = pwdata[7:0];
                REG_STABLE_VAR:   cfg_next.stable_variation   = pwdata[6:0];
                REG_FLICKER_LOW:  cfg_next.flicker_low        = pwdata[7:0];
                REG_FLICKER_HIGH: cfg_next.flicker_high       = pwdata[7:0];
                REG_SURGE_CHANCE: cfg_next.surge_chance       = pwdata[7:0];
                REG_SURGE_BOOST:  cfg_next.surge_boost        = pwdata[7:0];
                REG_REDRAW_IVAL:  cfg_next.redraw_interval_ms = pwdata[15:0];
                REG_SMOOTH_ALPHA: cfg_next.smoothing_alpha    = pwdata[8:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_level       <= 8'd200;
            cfg_reg.stable_variation   <= 7'd5;
            cfg_reg.flicker_low        <= 8'd80;
            cfg_reg.flicker_high       <= 8'd200;
            cfg_reg.surge_chance       <= 8'd5;
            cfg_reg.surge_boost        <= 8'd60;
            cfg_reg.redraw_interval_ms <= 16'd100;
            cfg_reg.smoothing_alpha    <= 9'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (idx)
            REG_STABLE_LEVEL: prdata = DATA_W'(cfg_reg.stable_level);
            REG_STABLE_VAR:   prdata = DATA_W'(cfg_reg.stable_variation);
            REG_FLICKER_LOW:  prdata = DATA_W'(cfg_reg.flicker_low);
            REG_FLICKER_HIGH: prdata = DATA_W'(cfg_reg.flicker_high);
            REG_SURGE_CHANCE: prdata = DATA_W'(cfg_reg.surge_chance);
            REG_SURGE_BOOST:  prdata = DATA_W'(cfg_reg.surge_boost);
            REG_REDRAW_IVAL:  prdata = DATA_W'(cfg_reg.redraw_interval_ms);
            REG_SMOOTH_ALPHA: prdata = DATA_W'(cfg_reg.smoothing_alpha);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/flg_ctrl.sv =====
// Frame sequencer: steps the datapath through one frame and owns the handshakes.
`default_nettype none

module flg_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire flg_pkg::sts_t sts,
    output flg_pkg::cmd_t      cmd
);
    import flg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_SURGE,
        ST_BOOST,
        ST_LEN,
        ST_TARGET,
        ST_SMOOTH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // Step decode and next state.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                cmd.phase  = 1'b1;
                state_next = sts.lamp_on ? ST_SURGE : ST_EMIT;
            end
            ST_SURGE:
            begin
                cmd.surge  = 1'b1;
                state_next = ST_BOOST;
            end
            ST_BOOST:
            begin
                cmd.boost  = 1'b1;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.len    = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.target = 1'b1;
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                cmd.smooth = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/flg_dp.sv =====
// Lamp state, shared 16x16 multiplier, target selection and Q8.8 smoother.
`default_nettype none

module flg_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire flg_pkg::cfg_t cfg,
    input  wire flg_pkg::cmd_t cmd,
    output flg_pkg::sts_t      sts,
    input  wire logic          lamp_on,
    input  wire logic [7:0]    elapsed_ms,
    input  wire logic [15:0]   duration_draw,
    input  wire logic [15:0]   level_draw,
    input  wire logic [15:0]   surge_draw,
    input  wire logic [15:0]   boost_draw,
    output logic      [7:0]    brightness,
    output logic               in_flicker
);
    import flg_pkg::*;

    // Latched frame.
    logic        on_reg;
    logic [7:0]  el_reg;
    logic [15:0] dd_reg, ld_reg, sd_reg, bd_reg;

    // Lamp state.
    logic        was_on_reg;
    logic        flick_reg;
    logic [15:0] ph_el_reg;
    logic [15:0] ph_len_reg;
    logic [15:0] rd_el_reg;
    logic        rd_due_reg;
    logic [7:0]  target_reg;
    logic [15:0] smooth_reg;

    // Per-frame working registers.
    logic        newlen_reg;
    logic        redraw_reg;
    logic        surge_reg;
    logic [7:0]  boost_reg;
    logic [31:0] prod_reg;
    logic [24:0] acc_reg;
    logic [7:0]  bright_reg;
    logic        flick_out_reg;

    logic [15:0] mul_a, mul_b;
    logic        mul_en;
    logic [15:0] prod_hi;
    logic [16:0] ph_sum, rd_sum;
    logic [15:0] ph_sat, rd_sat;
    logic [8:0]  alpha;
    logic [8:0]  lvl_span;
    logic [10:0] stb_t;
    logic [7:0]  stb_target;
    logic [8:0]  flk_base;
    logic [9:0]  flk_surge;
    logic [7:0]  flk_target;
    logic [24:0] smooth_sum;

    assign sts.lamp_on = on_reg;
    assign prod_hi     = prod_reg[31:16];
    assign brightness  = bright_reg;
    assign in_flicker  = flick_out_reg;

    // Saturating elapsed-time counters.
    assign ph_sum = {1'b0, ph_el_reg} + {9'd0, el_reg};
    assign rd_sum = {1'b0, rd_el_reg} + {9'd0, el_reg};
    assign ph_sat = ph_sum[16] ? 16'hFFFF : ph_sum[15:0];
    assign rd_sat = rd_sum[16] ? 16'hFFFF : rd_sum[15:0];

    // Alpha above one is treated as one.
    assign alpha = (cfg.smoothing_alpha > 9'd256) ? 9'd256 : cfg.smoothing_alpha;

    // Level draw span for the current phase.
    always_comb
    begin
        if (!flick_reg)
            lvl_span = {1'b0, cfg.stable_variation, 1'b1};
        else if (cfg.flicker_high >= cfg.flicker_low)
            lvl_span = {1'b0, cfg.flicker_high} - {1'b0, cfg.flicker_low} + 9'd1;
        else
            lvl_span = 9'd0;
    end

    // Stable target: base minus variation plus scaled draw, clamped.
    assign stb_t = $signed({3'b000, cfg.stable_level}) - $signed({4'b0000, cfg.stable_variation})
                 + $signed({2'b00, prod_hi[8:0]});
    always_comb
    begin
        if (stb_t[10])
            stb_target = 8'd0;
        else if (stb_t[9:0] > {2'b00, PWM_MAX})
            stb_target = PWM_MAX;
        else
            stb_target = stb_t[7:0];
    end

    // Flicker target: band draw, with an optional capped surge.
    assign flk_base  = {1'b0, cfg.flicker_low} + prod_hi[8:0];
    assign flk_surge = {1'b0, flk_base} + {2'b00, boost_reg};
    always_comb
    begin
        if (!surge_reg)
            flk_target = flk_base[7:0];
        else if (flk_surge > {2'b00, PWM_MAX})
            flk_target = PWM_MAX;
        else
            flk_target = flk_surge[7:0];
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.phase)
        begin
            mul_a = sd_reg;
            mul_b = SURGE_SPAN;
        end
        else if (cmd.surge)
        begin
            mul_a = bd_reg;
            mul_b = {8'd0, cfg.surge_boost};
        end
        else if (cmd.boost)
        begin
            mul_a = dd_reg;
            mul_b = flick_reg ? FLICKER_SPAN : STABLE_SPAN;
        end
        else if (cmd.len)
        begin
            mul_a = ld_reg;
            mul_b = {7'd0, lvl_span};
        end
        else if (cmd.target)
        begin
            mul_a = smooth_reg;
            mul_b = {7'd0, 9'd256 - alpha};
        end
        else if (cmd.smooth)
        begin
            mul_a = {target_reg, 8'd0};
            mul_b = {7'd0, alpha};
        end
    end

    // The product holds while the result waits for the output register.
    assign mul_en = cmd.phase | cmd.surge | cmd.boost | cmd.len | cmd.target | cmd.smooth;

    assign smooth_sum = acc_reg + prod_reg[24:0];

    // Frame latch, work registers and result register.
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            on_reg <= lamp_on;
            el_reg <= elapsed_ms;
            dd_reg <= duration_draw;
            ld_reg <= level_draw;
            sd_reg <= surge_draw;
            bd_reg <= boost_draw;
        end
        if (cmd.surge)
        begin
            surge_reg  <= ({8'd0, prod_hi[7:0]} < {8'd0, cfg.surge_chance}) && (prod_hi[15:8] == 8'd0);
            redraw_reg <= rd_due_reg || (rd_el_reg >= cfg.redraw_interval_ms);
        end
        if (cmd.boost)
            boost_reg <= prod_hi[7:0];
        if (cmd.smooth)
            acc_reg <= prod_reg[24:0];
        if (cmd.emit)
        begin
            bright_reg    <= on_reg ? smooth_sum[23:16] : 8'd0;
            flick_out_reg <= on_reg & flick_reg;
        end
    end

    // Lamp state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_on_reg <= 1'b0;
            flick_reg  <= 1'b0;
            ph_el_reg  <= '0;
            ph_len_reg <= '0;
            rd_el_reg  <= '0;
            rd_due_reg <= 1'b1;
            target_reg <= '0;
            smooth_reg <= '0;
            newlen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.phase)
            begin
                if (!on_reg)
                begin
                    was_on_reg <= 1'b0;
                    newlen_reg <= 1'b0;
                end
                else if (!was_on_reg)
                begin
                    was_on_reg <= 1'b1;
                    flick_reg  <= 1'b0;
                    ph_el_reg  <= '0;
                    rd_el_reg  <= '0;
                    rd_due_reg <= 1'b1;
                    target_reg <= cfg.stable_level;
                    smooth_reg <= {cfg.stable_level, 8'd0};
                    newlen_reg <= 1'b1;
                end
                else
                begin
                    rd_el_reg <= rd_sat;
                    if (ph_sat >= ph_len_reg)
                    begin
                        flick_reg  <= ~flick_reg;
                        ph_el_reg  <= '0;
                        rd_due_reg <= 1'b1;
                        newlen_reg <= 1'b1;
                    end
                    else
                    begin
                        ph_el_reg  <= ph_sat;
                        newlen_reg <= 1'b0;
                    end
                end
            end
            if (cmd.len && newlen_reg)
                ph_len_reg <= (flick_reg ? FLICKER_MIN : STABLE_MIN) + prod_hi;
            if (cmd.target && redraw_reg)
            begin
                rd_el_reg  <= '0;
                rd_due_reg <= 1'b0;
                target_reg <= flick_reg ? flk_target : stb_target;
            end
            if (cmd.emit && on_reg)
                smooth_reg <= smooth_sum[23:8];
        end
    end

endmodule

`default_nettype wire

// ===== src/flicker_lamp_intensity_generator.sv =====
// Top level of the flickering lamp intensity generator.
`default_nettype none

// Each input beat is one refresh frame and yields exactly one output beat with the
// brightness and the flicker flag. A frame that keeps the lamp on passes from idle
// through the phase, surge, boost, length, target, smooth and emit steps, and its
// result is registered in emit: the sequencer shares one 16x16 multiplier across the
// surge, boost, phase-length and level draws and the two smoother products, one
// product per cycle. A frame with the lamp off goes from phase straight to emit. The
// last step waits, and the product is held, for as long as the previous result still
// sits untaken in the output register. The next frame is accepted as soon as the
// sequencer is back in idle, even while the previous result still waits there. The user
// writes configuration only while no frame is in progress; the block does not enforce it.
module flicker_lamp_intensity_generator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input frame.
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [0] lamp_on, [8:1] elapsed_ms, [24:9] duration_draw, [40:25] level_draw,
    // [56:41] surge_draw, [72:57] boost_draw, [79:73] zero
    input  wire logic [79:0]                s_tdata,
    // Output result.
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [7:0] brightness, [8] in_flicker, [15:9] zero
    output logic      [15:0]                m_tdata,
    // Configuration.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [flg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [flg_pkg::DATA_W-1:0] pwdata,
    output logic      [flg_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import flg_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] brightness;
    logic       in_flicker;

    flg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    flg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .lamp_on       (s_tdata[0]),
        .elapsed_ms    (s_tdata[8:1]),
        .duration_draw (s_tdata[24:9]),
        .level_draw    (s_tdata[40:25]),
        .surge_draw    (s_tdata[56:41]),
        .boost_draw    (s_tdata[72:57]),
        .brightness    (brightness),
        .in_flicker    (in_flicker)
    );

    assign m_tdata = {7'd0, in_flicker, brightness};

    // At most one datapath step is commanded per cycle.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath step commanded");

    // The result register is written only when its previous beat is gone.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    // A frame is still in progress after it is accepted, so no frame follows in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("frame accepted while another is in progress");

endmodule

`default_nettype wire

// ===== bench/flicker_lamp_intensity_generator_check.sv =====
// Checker that predicts each lamp output beat and compares it with the block's result.
`default_nettype none

module flicker_lamp_intensity_generator_check
    import flg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    // [0] lamp_on, [8:1] elapsed_ms, [24:9] duration_draw, [40:25] level_draw,
    // [56:41] surge_draw, [72:57] boost_draw, [79:73] zero
    input  wire logic [79:0]       s_tdata,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    // [7:0] brightness, [8] in_flicker, [15:9] zero
    input  wire logic [15:0]       m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic        in_flicker;
        logic [7:0]  brightness;
    } lamp_out_t;

    typedef struct packed {
        logic        was_on;
        logic        flicker;
        logic [15:0] phase_ms;
        logic [15:0] phase_len;
        logic [15:0] redraw_ms;
        logic        redraw_due;
        logic [7:0]  target;
        logic [15:0] level;
    } lamp_state_t;

    cfg_t        cfg;
    lamp_state_t lamp;
    lamp_out_t   pending_levels[$];
    lamp_out_t   seen;
    lamp_out_t   want;
    int          errors;

    // Scale a uniform 16-bit draw into [0, span).
    function automatic int unsigned scale_draw(logic [15:0] d, int unsigned span);
        int unsigned p;
        p = d * span;
        return p >> 16;
    endfunction

    // Draw a phase length in [lo, hi); an empty range gives lo.
    function automatic int unsigned draw_length(logic [15:0] d, int unsigned lo,
                                                int unsigned hi);
        return (hi > lo) ? lo + scale_draw(d, hi - lo) : lo;
    endfunction

    function automatic logic [15:0] sat16(logic [15:0] a, logic [7:0] b);
        int unsigned s;
        s = a + b;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    // New target level for the current phase.
    function automatic logic [7:0] redraw_level(logic [15:0] ld, logic [15:0] sd,
                                                logic [15:0] bd);
        int          spread;
        int          steady;
        int unsigned lo;
        int unsigned hi;
        int unsigned t;
        int unsigned boosted;
        if (!lamp.flicker) begin
            spread = cfg.stable_variation;
            steady = int'(cfg.stable_level) - spread + int'(scale_draw(ld, 2 * spread + 1));
            if (steady < 0) steady = 0;
            if (steady > MAX_PWM) steady = MAX_PWM;
            return steady[7:0];
        end
        lo = cfg.flicker_low;
        hi = cfg.flicker_high;
        t  = lo;
        if (hi >= lo) t += scale_draw(ld, hi - lo + 1);
        // A surge adds a random boost and is capped at the PWM ceiling.
        if (scale_draw(sd, SURGE_RANGE) < cfg.surge_chance) begin
            boosted = t + scale_draw(bd, cfg.surge_boost);
            t = (boosted > MAX_PWM) ? MAX_PWM : boosted;
        end
        return t[7:0];
    endfunction

    // Advance the lamp by one frame and return the beat it should produce.
    function automatic lamp_out_t advance_lamp(logic [79:0] beat);
        logic        on;
        logic [7:0]  el;
        logic [15:0] dd;
        logic [15:0] ld;
        logic [15:0] sd;
        logic [15:0] bd;
        int unsigned alpha;
        int unsigned tgt;
        int unsigned mix;
        lamp_out_t   res;
        on  = beat[0];
        el  = beat[8:1];
        dd  = beat[24:9];
        ld  = beat[40:25];
        sd  = beat[56:41];
        bd  = beat[72:57];
        res = '0;
        if (!on) begin
            lamp.was_on = 1'b0;
            return res;
        end
        if (!lamp.was_on) begin
            // Switching on restarts the lamp in the stable phase at its base level.
            lamp.was_on     = 1'b1;
            lamp.flicker    = 1'b0;
            lamp.phase_ms   = '0;
            lamp.phase_len  = 16'(draw_length(dd, STABLE_MIN_MS, STABLE_MAX_MS));
            lamp.target     = cfg.stable_level;
            lamp.level      = {cfg.stable_level, 8'h00};
            lamp.redraw_ms  = '0;
            lamp.redraw_due = 1'b1;
        end else begin
            lamp.phase_ms  = sat16(lamp.phase_ms, el);
            lamp.redraw_ms = sat16(lamp.redraw_ms, el);
            if (lamp.phase_ms >= lamp.phase_len) begin
                lamp.flicker    = !lamp.flicker;
                lamp.phase_ms   = '0;
                lamp.phase_len  = lamp.flicker
                    ? 16'(draw_length(dd, FLICKER_MIN_MS, FLICKER_MAX_MS))
                    : 16'(draw_length(dd, STABLE_MIN_MS, STABLE_MAX_MS));
                lamp.redraw_due = 1'b1;
            end
        end
        if (lamp.redraw_due || lamp.redraw_ms >= cfg.redraw_interval_ms) begin
            lamp.redraw_ms  = '0;
            lamp.redraw_due = 1'b0;
            lamp.target     = redraw_level(ld, sd, bd);
        end
        // Q8.8 exponential smoother toward the target.
        alpha = (cfg.smoothing_alpha > 9'd256) ? 256 : cfg.smoothing_alpha;
        tgt   = lamp.target;
        mix   = ((256 - alpha) * lamp.level + alpha * (tgt << 8)) >> 8;
        lamp.level     = mix[15:0];
        res.brightness = lamp.level[15:8];
        res.in_flicker = lamp.flicker;
        return res;
    endfunction

    // Track register writes, predict accepted frames and compare result beats.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg             = '{8'd200, 7'd5, 8'd80, 8'd200, 8'd5, 8'd60, 16'd100, 9'd64};
            lamp            = '0;
            lamp.redraw_due = 1'b1;
            pending_levels.delete();
            errors          = 0;
            fail_count     <= 0;
            outstanding    <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_STABLE_LEVEL: cfg.stable_level       = pwdata[7:0];
                    REG_STABLE_VAR:   cfg.stable_variation   = pwdata[6:0];
                    REG_FLICKER_LOW:  cfg.flicker_low        = pwdata[7:0];
                    REG_FLICKER_HIGH: cfg.flicker_high       = pwdata[7:0];
                    REG_SURGE_CHANCE: cfg.surge_chance       = pwdata[7:0];
                    REG_SURGE_BOOST:  cfg.surge_boost        = pwdata[7:0];
                    REG_REDRAW_IVAL:  cfg.redraw_interval_ms = pwdata[15:0];
                    REG_SMOOTH_ALPHA: cfg.smoothing_alpha    = pwdata[8:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata[8:0];
                if (pending_levels.size() == 0) begin
                    errors++;
                    $error("result beat with no frame pending: brightness %0d, in_flicker %0d",
                           seen.brightness, seen.in_flicker);
                end else begin
                    want = pending_levels.pop_front();
                    if (seen.brightness !== want.brightness) begin
                        errors++;
                        $error("brightness: expected %0d, got %0d",
                               want.brightness, seen.brightness);
                    end
                    if (seen.in_flicker !== want.in_flicker) begin
                        errors++;
                        $error("in_flicker: expected %0d, got %0d",
                               want.in_flicker, seen.in_flicker);
                    end
                end
            end
            if (s_tvalid && s_tready) pending_levels.push_back(advance_lamp(s_tdata));
            fail_count  <= errors;
            outstanding <= pending_levels.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/flicker_lamp_intensity_generator_test.sv =====
// Testbench top that drives frames and register settings into the lamp generator.
`default_nettype none

module flicker_lamp_intensity_generator_test;
    import flg_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_FRAMES = 230;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // [0] lamp_on, [8:1] elapsed_ms, [24:9] duration_draw, [40:25] level_draw,
    // [56:41] surge_draw, [72:57] boost_draw, [79:73] zero
    logic [79:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [7:0] brightness, [8] in_flicker, [15:9] zero
    logic [15:0]       m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    bit hold_off     = 1'b0;
    bit gaps_off     = 1'b0;

    flicker_lamp_intensity_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    flicker_lamp_intensity_generator_check checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one frame and hold it until the block takes the beat.
    task automatic send_frame(bit on, bit [7:0] el, bit [15:0] dd, bit [15:0] ld,
                              bit [15:0] sd, bit [15:0] bd);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bd, sd, ld, dd, el, on};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        gap = gaps_off ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Long on-runs with random draws; an occasional off frame restarts the lamp.
    task automatic send_random_frame();
        bit        on;
        bit [7:0]  el;
        bit [15:0] sd;
        on = ($urandom_range(0, 49) != 0);
        case ($urandom_range(0, 9))
            0:       el = 8'h00;
            1:       el = 8'hFF;
            default: el = 8'($urandom_range(0, 255));
        endcase
        // Bias some surge draws low so surges also happen at small chances.
        sd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
        send_frame(on, el, 16'($urandom), 16'($urandom), sd, 16'($urandom));
    endtask

    // Stop offering and wait for every pending result beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(int level, int spread, int low, int high, int chance,
                                int boost, int interval, int alpha);
        write_reg(REG_STABLE_LEVEL, level);
        write_reg(REG_STABLE_VAR, spread);
        write_reg(REG_FLICKER_LOW, low);
        write_reg(REG_FLICKER_HIGH, high);
        write_reg(REG_SURGE_CHANCE, chance);
        write_reg(REG_SURGE_BOOST, boost);
        write_reg(REG_REDRAW_IVAL, interval);
        write_reg(REG_SMOOTH_ALPHA, alpha);
    endtask

    // Fixed extremes first, then random settings across the full register widths.
    task automatic apply_setting(int phase);
        case (phase)
            1: load_setting(0, 64, 0, 0, 255, 255, 0, 256);
            2: load_setting(255, 127, 255, 255, 255, 255, 65535, 511);
            3: load_setting(128, 0, 0, 0, 0, 0, 1, 0);
            4: load_setting(128, 0, 200, 50, 100, 0, 1, 300);
            default: load_setting($urandom_range(0, 255), $urandom_range(0, 127),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(1, 400),
                                  $urandom_range(0, 511));
        endcase
    endtask

    // Result side: random ready bursts and gaps, plus one long hold-off on request.
    initial begin
        int burst;
        int gap;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end else begin
                m_tready <= 1'b1;
                burst = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
                repeat (burst) @(posedge clk);
                gap = idle_length();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // End the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("flicker_lamp_intensity_generator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Off frame with every field at its top value.
        send_frame(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Switch on with the shortest stable phase; elapsed time is ignored here.
        send_frame(1'b1, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_frame(1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Run into the flicker phase with a surge that hits the PWM ceiling.
        repeat (8) send_frame(1'b1, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        // Flicker frames at the redraw interval, no surge, lowest level.
        repeat (3) send_frame(1'b1, 8'd100, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        // Back to stable with the longest phase length.
        send_frame(1'b1, 8'hFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000);
        send_frame(1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_frame(1'b1, 8'h01, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase > 0) apply_setting(phase);
            gaps_off = (phase == 2 || phase == 5);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                // Stall the result side while frames keep coming.
                if (phase == 2 && n == 40) hold_off = 1'b1;
                send_random_frame();
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("flicker_lamp_intensity_generator verification clean");
        else
            $display("flicker_lamp_intensity_generator verification failed");
        $finish;
    end

endmodule

`default_nettype wire
